// ===== rtl/lbph_pkg.sv =====
// shared types and constants of the lbp rotated histogram unit
package lbph_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_PIXEL  = 2'd0,
      OP_READ   = 2'd1,
      OP_START  = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   // kind of an item once it travels down the pipeline
   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_READ  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   // register indexes, decoded from paddr bit 2
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam int unsigned CFG_BITS = 11;

   // gray = (299r + 587g + 114b + 500) / 1000
   localparam int unsigned GRAY_WR    = 299;
   localparam int unsigned GRAY_WG    = 587;
   localparam int unsigned GRAY_WB    = 114;
   localparam int unsigned GRAY_ROUND = 500;
   localparam int unsigned SUM_BITS   = 18;
   // ceil(2^28 / 1000), exact for sums below 2^18
   localparam int unsigned GRAY_RECIP = 268436;
   localparam int unsigned GRAY_SHIFT = 28;
   localparam int unsigned PROD_BITS  = 37;

   localparam int unsigned BIN_COUNT  = 256;
   localparam int unsigned BIN_BITS   = 8;
   localparam int unsigned COUNT_BITS = 20;
   localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

   // result queue
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_AW    = 3;

endpackage

// ===== rtl/lbp_rotated_histogram_unit.sv =====
// top level: gray conversion, line buffer, 3x3 window, lbp code and histogram
// a read item's result passes stages 1 to 4 and the result queue before it is offered
// throughput: one item per cycle; line buffer and histogram are single read-modify-write
//   memories with forwarding; an 8-entry result queue bounds reads and stalls input
// reset: synchronous, clears counters, window, histogram valid bits and registers
//   to width and height 1024 (clamped to the limits); a start item clears the histogram
//   at once through its valid bits, no clearing pass
module lbp_rotated_histogram_unit
   import lbph_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], bin_index[31:24]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // bin_echo[7:0], bin_count[27:8], zero[31:28]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);       // column index bits
   localparam int RW = $clog2(MAX_HEIGHT) + 1;  // row counter, holds the height itself
   localparam int WIDTH_RST  = (MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024;
   localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   function automatic logic [12:0] clamp_dim(input logic [CFG_BITS-1:0] raw,
                                             input logic [12:0] hi);
      logic [12:0] v;
      v = {2'b00, raw};
      if (v < 13'd3) return 13'd3;
      else if (v > hi) return hi;
      else return v;
   endfunction

   // rotate right until bit 0 is set, zero stays zero
   function automatic logic [7:0] rotate_code(input logic [7:0] code);
      logic [15:0] dbl;
      logic [7:0]  res;
      dbl = {code, code};
      res = code;
      for (int k = 7; k >= 0; k--) begin
         if (code[k]) res = dbl[k +: 8];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- config
   logic [CFG_BITS-1:0] width_raw_ff, height_raw_ff;
   logic [CW:0]         width_use_ff, width_use_in;
   logic [RW-1:0]       height_use_ff, height_use_in;
   logic [12:0]         width_clamp, height_clamp;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_clamp   = clamp_dim(csr_pwdata[CFG_BITS-1:0], 13'(MAX_WIDTH));
      height_clamp  = clamp_dim(csr_pwdata[CFG_BITS-1:0], 13'(MAX_HEIGHT));
      width_use_in  = width_clamp[CW:0];
      height_use_in = height_clamp[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= CFG_BITS'(1024);
         height_raw_ff <= CFG_BITS'(1024);
         width_use_ff  <= (CW+1)'(WIDTH_RST);
         height_use_ff <= RW'(HEIGHT_RST);
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_WIDTH) begin
            width_raw_ff <= csr_pwdata[CFG_BITS-1:0];
            width_use_ff <= width_use_in;
         end else begin
            height_raw_ff <= csr_pwdata[CFG_BITS-1:0];
            height_use_ff <= height_use_in;
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_HEIGHT) csr_prdata = {21'b0, height_raw_ff};
      else csr_prdata = {21'b0, width_raw_ff};
   end

   // ---------------------------------------------------------------- stage 0: accept
   op_type              op;
   logic [7:0]          in_red, in_green, in_blue, in_bin;
   logic                in_fire, pix_take, read_take, start_take;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW:0]         col_plus;
   logic                cnt_en;
   logic [SUM_BITS-1:0] gray_sum;
   logic [3:0]          credit_ff;

   assign op       = op_type'(req_tuser);
   assign in_red   = req_tdata[7:0];
   assign in_green = req_tdata[15:8];
   assign in_blue  = req_tdata[23:16];
   assign in_bin   = req_tdata[31:24];

   // room is kept in the result queue for every read still in flight
   assign req_tready = credit_ff < 4'(FIFO_DEPTH);
   assign in_fire    = req_tvalid & req_tready;

   always_comb begin
      pix_take   = 1'b0;
      read_take  = 1'b0;
      start_take = 1'b0;
      col_in     = col_ff;
      row_in     = row_ff;
      col_plus   = {1'b0, col_ff} + (CW+1)'(1);
      cnt_en     = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      gray_sum   = SUM_BITS'(GRAY_WR) * {10'b0, in_red}
                 + SUM_BITS'(GRAY_WG) * {10'b0, in_green}
                 + SUM_BITS'(GRAY_WB) * {10'b0, in_blue}
                 + SUM_BITS'(GRAY_ROUND);
      if (in_fire) begin
         unique case (op)
            OP_PIXEL: begin
               // rows past the height are dropped
               if (row_ff < height_use_ff) begin
                  pix_take = 1'b1;
                  if (col_plus >= width_use_ff) begin
                     col_in = '0;
                     row_in = row_ff + RW'(1);
                  end else begin
                     col_in = col_plus[CW-1:0];
                  end
               end
            end
            OP_READ:  read_take = 1'b1;
            OP_START: begin
               start_take = 1'b1;
               col_in     = '0;
               row_in     = '0;
            end
            OP_IGNORE: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line buffer
   // one word per column: older row in [15:8], newer row in [7:0]
   logic [15:0]   line_mem [MAX_WIDTH];
   logic [15:0]   line_rd_ff;
   logic          line_we;
   logic [CW-1:0] line_waddr;
   logic [15:0]   line_wdata;
   logic          line_last_valid_ff;
   logic [CW-1:0] line_last_addr_ff;
   logic [15:0]   line_last_data_ff;

   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_waddr] <= line_wdata;
      line_rd_ff <= line_mem[col_ff];
   end

   // ---------------------------------------------------------------- stage 1: gray
   logic                s1_valid_ff;
   kind_type            s1_kind_ff;
   logic [CW-1:0]       s1_col_ff;
   logic                s1_cnt_ff;
   logic [SUM_BITS-1:0] s1_sum_ff;
   logic [7:0]          s1_bin_ff;
   kind_type            s0_kind;

   always_comb begin
      priority if (read_take) s0_kind = KIND_READ;
      else if (start_take) s0_kind = KIND_START;
      else s0_kind = KIND_PIXEL;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= pix_take | read_take | start_take;
      s1_kind_ff <= s0_kind;
      s1_col_ff  <= col_ff;
      s1_cnt_ff  <= cnt_en;
      s1_sum_ff  <= gray_sum;
      s1_bin_ff  <= in_bin;
   end

   logic                 s2_valid_ff;
   kind_type             s2_kind_ff;
   logic [CW-1:0]        s2_col_ff;
   logic                 s2_cnt_ff;
   logic [7:0]           s2_gray_ff, s2_older_ff, s2_newer_ff, s2_bin_ff;
   logic [15:0]          line_word;
   logic [PROD_BITS-1:0] gray_prod;
   logic [7:0]           s1_gray;

   // forward column writes that the memory read could not see yet
   always_comb begin
      priority if (s2_valid_ff && s2_kind_ff == KIND_PIXEL && s2_col_ff == s1_col_ff)
         line_word = {s2_newer_ff, s2_gray_ff};
      else if (line_last_valid_ff && line_last_addr_ff == s1_col_ff)
         line_word = line_last_data_ff;
      else
         line_word = line_rd_ff;
      // division by 1000 as a reciprocal multiply
      gray_prod = PROD_BITS'(s1_sum_ff) * PROD_BITS'(GRAY_RECIP);
      s1_gray   = gray_prod[GRAY_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else s2_valid_ff <= s1_valid_ff;
      s2_kind_ff  <= s1_kind_ff;
      s2_col_ff   <= s1_col_ff;
      s2_cnt_ff   <= s1_cnt_ff;
      s2_gray_ff  <= s1_gray;
      s2_older_ff <= line_word[15:8];
      s2_newer_ff <= line_word[7:0];
      s2_bin_ff   <= s1_bin_ff;
   end

   // ---------------------------------------------------------------- stage 2: window, line write
   logic [7:0] window_ff [9];

   assign line_we    = s2_valid_ff && s2_kind_ff == KIND_PIXEL;
   assign line_waddr = s2_col_ff;
   assign line_wdata = {s2_newer_ff, s2_gray_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         line_last_valid_ff <= 1'b0;
      end else begin
         line_last_valid_ff <= line_we;
      end
      line_last_addr_ff <= line_waddr;
      line_last_data_ff <= line_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) window_ff[i] <= '0;
      end else if (line_we) begin
         // shift left, new column on the right
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= s2_older_ff;
         window_ff[3] <= window_ff[4];
         window_ff[4] <= window_ff[5];
         window_ff[5] <= s2_newer_ff;
         window_ff[6] <= window_ff[7];
         window_ff[7] <= window_ff[8];
         window_ff[8] <= s2_gray_ff;
      end
   end

   logic       s3_valid_ff;
   kind_type   s3_kind_ff;
   logic       s3_cnt_ff;
   logic [7:0] s3_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else s3_valid_ff <= s2_valid_ff;
      s3_kind_ff <= s2_kind_ff;
      s3_cnt_ff  <= s2_cnt_ff;
      s3_bin_ff  <= s2_bin_ff;
   end

   // ---------------------------------------------------------------- stage 3: code, histogram read
   logic [7:0]            lbp_code, lbp_rot, hist_raddr;
   logic [COUNT_BITS-1:0] hist_mem [BIN_COUNT];
   logic [COUNT_BITS-1:0] hist_rd_ff;
   logic                  hist_we;
   logic [BIN_BITS-1:0]   hist_waddr;
   logic [COUNT_BITS-1:0] hist_wdata;

   always_comb begin
      // clockwise from upper left, upper left in the msb
      lbp_code = {window_ff[0] >= window_ff[4], window_ff[1] >= window_ff[4],
                  window_ff[2] >= window_ff[4], window_ff[5] >= window_ff[4],
                  window_ff[8] >= window_ff[4], window_ff[7] >= window_ff[4],
                  window_ff[6] >= window_ff[4], window_ff[3] >= window_ff[4]};
      lbp_rot    = rotate_code(lbp_code);
      hist_raddr = (s3_kind_ff == KIND_PIXEL) ? lbp_rot : s3_bin_ff;
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   logic       s4_valid_ff;
   kind_type   s4_kind_ff;
   logic       s4_cnt_ff;
   logic [7:0] s4_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else s4_valid_ff <= s3_valid_ff;
      s4_kind_ff <= s3_kind_ff;
      s4_cnt_ff  <= s3_cnt_ff;
      s4_bin_ff  <= hist_raddr;
   end

   // ---------------------------------------------------------------- stage 4: count update
   logic [BIN_COUNT-1:0]  hist_valid_ff;
   logic                  hist_last_valid_ff;
   logic [BIN_BITS-1:0]   hist_last_addr_ff;
   logic [COUNT_BITS-1:0] hist_last_data_ff;
   logic [COUNT_BITS-1:0] count_cur;
   logic                  fifo_push;

   always_comb begin
      // the previous cycle's write is newer than the memory read
      priority if (hist_last_valid_ff && hist_last_addr_ff == s4_bin_ff)
         count_cur = hist_last_data_ff;
      else if (hist_valid_ff[s4_bin_ff])
         count_cur = hist_rd_ff;
      else
         count_cur = '0;
      hist_we    = s4_valid_ff && s4_kind_ff == KIND_PIXEL && s4_cnt_ff;
      hist_waddr = s4_bin_ff;
      hist_wdata = (count_cur == COUNT_CEIL) ? count_cur : count_cur + COUNT_BITS'(1);
      fifo_push  = s4_valid_ff && s4_kind_ff == KIND_READ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff      <= '0;
         hist_last_valid_ff <= 1'b0;
      end else begin
         hist_last_valid_ff <= hist_we;
         // a start empties every bin at once
         if (s4_valid_ff && s4_kind_ff == KIND_START) hist_valid_ff <= '0;
         else if (hist_we) hist_valid_ff[hist_waddr] <= 1'b1;
      end
      hist_last_addr_ff <= hist_waddr;
      hist_last_data_ff <= hist_wdata;
   end

   // ---------------------------------------------------------------- result queue
   logic [BIN_BITS+COUNT_BITS-1:0] fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]             fifo_wr_ff, fifo_rd_ff;
   logic [FIFO_AW:0]               fifo_cnt_ff;
   logic                           rsp_fire;

   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {4'b0, fifo_mem[fifo_rd_ff]};

   always_ff @(posedge clock) begin
      if (fifo_push) fifo_mem[fifo_wr_ff] <= {count_cur, s4_bin_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff  <= '0;
         fifo_rd_ff  <= '0;
         fifo_cnt_ff <= '0;
         credit_ff   <= '0;
      end else begin
         if (fifo_push) fifo_wr_ff <= fifo_wr_ff + FIFO_AW'(1);
         if (rsp_fire) fifo_rd_ff <= fifo_rd_ff + FIFO_AW'(1);
         unique case ({fifo_push, rsp_fire})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + (FIFO_AW+1)'(1);
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - (FIFO_AW+1)'(1);
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
         // reads accepted and not yet delivered
         unique case ({read_take, rsp_fire})
            2'b10:   credit_ff <= credit_ff + 4'd1;
            2'b01:   credit_ff <= credit_ff - 4'd1;
            default: credit_ff <= credit_ff;
         endcase
      end
   end

endmodule
